>>> sv/assert_macros.svh
// Assertion macros shared by the escape-time RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time block.
// Used by the controller, datapath and top level; no dependencies.
package mbe_pkg;

	// Default parameter values
	localparam int FRACTION_BITS_DEF = 28;
	localparam int MAX_LIMIT_DEF     = 5000;

	// Field and register widths
	localparam int COORD_W      = 32;
	localparam int LIMIT_W      = 13;
	localparam int COUNT_W      = 13;
	localparam int MAG_W        = 40;
	localparam int IN_TDATA_W   = 64;
	localparam int OUT_TDATA_W  = 56;
	localparam int OUT_TUSER_W  = 2;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;
	localparam int CFG_IDX_W    = 1;

	// Register map
	localparam int unsigned REG_ITERATION_LIMIT = 0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd500;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHAPE_MUL,
		ST_SHAPE_SUM,
		ST_SHAPE_Q,
		ST_CARD_MUL,
		ST_CARD_SUM,
		ST_SHAPE_DECIDE,
		ST_ITER_MUL,
		ST_ITER_SUM,
		ST_ITER_STEP,
		ST_FINISH
	} state_t;

	// Operand set fed to the multipliers
	typedef enum logic [1:0] {
		OP_SHAPE,
		OP_CARD,
		OP_ITER
	} op_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;
		logic    mul_en1;
		logic    mul_en2;
		op_sel_t op_sel;
		logic    shape_q;
		logic    shape_decide;
		logic    step;
		logic    load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic far;
		logic hit;
		logic stop;
	} dp_status_t;

endpackage

>>> sv/mbe_mul.sv
// Two-stage signed multiplier built from half-width partial products.
// Stand-alone; instanced three times by mbe_dp.
module mbe_mul #(
	parameter int W = 34
) (
	input  logic                  clk,
	input  logic                  en1,
	input  logic                  en2,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	localparam int H  = (W + 1) / 2;
	localparam int HI = W - H;
	localparam int PW = 2 * W;

	logic signed [HI-1:0]     a_hi, b_hi;
	logic signed [H:0]        a_lo, b_lo;
	logic signed [2*HI-1:0]   hh_s1;
	logic signed [HI+H:0]     hl_s1, lh_s1;
	logic        [2*H-1:0]    ll_s1;
	logic signed [PW-1:0]     hh_x, hl_x, lh_x, ll_x;
	logic signed [PW-1:0]     p_s2;

	// split operands: signed upper half, unsigned lower half
	assign a_hi = a[W-1:H];
	assign b_hi = b[W-1:H];
	assign a_lo = $signed({1'b0, a[H-1:0]});
	assign b_lo = $signed({1'b0, b[H-1:0]});

	// stage 1: partial products
	always_ff @(posedge clk) begin
		if (en1) begin
			hh_s1 <= a_hi * b_hi;
			hl_s1 <= a_hi * b_lo;
			lh_s1 <= a_lo * b_hi;
			ll_s1 <= a[H-1:0] * b[H-1:0];
		end
	end

	assign hh_x = PW'(hh_s1);
	assign hl_x = PW'(hl_s1);
	assign lh_x = PW'(lh_s1);
	assign ll_x = PW'(ll_s1);

	// stage 2: recombine
	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= (hh_x <<< (2 * H)) + ((hl_x + lh_x) <<< H) + ll_x;
		end
	end

	assign p = p_s2;

endmodule

>>> sv/mbe_ctrl.sv
// Sequencer for the escape-time block: shape test, iteration loop, result hand-off.
// Depends on mbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mbe_pkg::dp_status_t status,
	output mbe_pkg::dp_cmd_t    cmd
);
	import mbe_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// state register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.op_sel = OP_ITER;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.far ? ST_ITER_MUL : ST_SHAPE_MUL;
				end
			end
			ST_SHAPE_MUL: begin
				cmd.mul_en1 = 1'b1;
				cmd.op_sel  = OP_SHAPE;
				state_d     = ST_SHAPE_SUM;
			end
			ST_SHAPE_SUM: begin
				cmd.mul_en2 = 1'b1;
				state_d     = ST_SHAPE_Q;
			end
			ST_SHAPE_Q: begin
				cmd.shape_q = 1'b1;
				state_d     = ST_CARD_MUL;
			end
			ST_CARD_MUL: begin
				cmd.mul_en1 = 1'b1;
				cmd.op_sel  = OP_CARD;
				state_d     = ST_CARD_SUM;
			end
			ST_CARD_SUM: begin
				cmd.mul_en2 = 1'b1;
				state_d     = ST_SHAPE_DECIDE;
			end
			ST_SHAPE_DECIDE: begin
				cmd.shape_decide = 1'b1;
				state_d          = status.hit ? ST_FINISH : ST_ITER_MUL;
			end
			ST_ITER_MUL: begin
				cmd.mul_en1 = 1'b1;
				cmd.op_sel  = OP_ITER;
				state_d     = ST_ITER_SUM;
			end
			ST_ITER_SUM: begin
				cmd.mul_en2 = 1'b1;
				state_d     = ST_ITER_STEP;
			end
			ST_ITER_STEP: begin
				cmd.step = 1'b1;
				state_d  = status.stop ? ST_FINISH : ST_ITER_MUL;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// checks
	`ASSERT_HOLDS(a_load_out_free, cmd.load_out |-> (!out_valid_q || out_ready), "result overwritten before taken")
	`ASSERT_HOLDS(a_accept_leaves_idle, (in_valid && in_ready) |=> (state_q != ST_IDLE), "accepted beat not started")
	`ASSERT_HOLDS(a_valid_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result valid without finish")

endmodule

>>> sv/mbe_dp.sv
// Datapath for the escape-time block: point registers, shape test, z update, result.
// Depends on mbe_pkg, mbe_mul and assert_macros.svh.
`include "assert_macros.svh"

module mbe_dp #(
	parameter int FRACTION_BITS = mbe_pkg::FRACTION_BITS_DEF,
	parameter int MAX_LIMIT     = mbe_pkg::MAX_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mbe_pkg::dp_cmd_t                    cmd,
	output mbe_pkg::dp_status_t                 status,
	input  logic signed [mbe_pkg::COORD_W-1:0]  c_real,
	input  logic signed [mbe_pkg::COORD_W-1:0]  c_imag,
	input  logic        [mbe_pkg::LIMIT_W-1:0]  iteration_limit,
	output logic        [mbe_pkg::COUNT_W-1:0]  iteration_count,
	output logic        [mbe_pkg::MAG_W-1:0]    final_magnitude_sq,
	output logic                                limit_reached,
	output logic                                in_cardioid_or_bulb
);
	import mbe_pkg::*;

	localparam int F   = FRACTION_BITS;
	localparam int ZW  = ((F > 28) ? F : 28) + 6;
	localparam int PW  = 2 * ZW;
	localparam int PW1 = PW + 1;
	localparam int CW  = $clog2(MAX_LIMIT + 1);
	localparam int EW  = (CW > LIMIT_W) ? CW : LIMIT_W;

	localparam logic signed [ZW-1:0]  Z_ONE     = ZW'(1) <<< F;
	localparam logic signed [ZW-1:0]  Z_TWO     = ZW'(1) <<< (F + 1);
	localparam logic signed [ZW-1:0]  Z_QUARTER = ZW'(1) <<< (F - 2);
	localparam logic signed [PW1-1:0] MAG_FOUR  = PW1'(1) <<< (2 * F + 2);
	localparam logic signed [PW1-1:0] BULB_R    = PW1'(1) <<< (2 * F - 4);
	localparam logic        [EW-1:0]  MAX_E     = EW'(MAX_LIMIT);

	logic signed [ZW-1:0]  cr_in, ci_in;
	logic signed [ZW-1:0]  cr_q, ci_q, x_q, y_q, q_q, qx_q, zr_q, zi_q;
	logic signed [PW-1:0]  ci4_q;
	logic                  bulb_q, hit_q;
	logic        [CW-1:0]  count_q, limit_q, limit_eff;
	logic        [EW-1:0]  lim_e;
	logic signed [ZW-1:0]  a0, b0, a1, b1, a2, b2;
	logic signed [PW-1:0]  p0, p1, p2;
	logic signed [PW1-1:0] q_sum, bulb_sum, mag, diff;
	logic signed [ZW-1:0]  q_next, zr_next, zi_next;
	logic                  card;
	logic        [MAG_W-1:0] mag_sat;
	logic [COUNT_W-1:0]    res_count_q;
	logic [MAG_W-1:0]      res_mag_q;
	logic                  res_limit_q, res_hit_q;

	// point inputs widened to the z format
	assign cr_in = ZW'(c_real);
	assign ci_in = ZW'(c_imag);

	// points with |c| >= 2 in either part skip the shape test
	assign status.far = (cr_in <= -Z_TWO) || (cr_in >= Z_TWO) ||
	                    (ci_in <= -Z_TWO) || (ci_in >= Z_TWO);

	// effective limit: zero acts as one, clamp at the maximum
	always_comb begin
		priority if (iteration_limit == '0) begin
			lim_e = EW'(1);
		end else if (EW'(iteration_limit) > MAX_E) begin
			lim_e = MAX_E;
		end else begin
			lim_e = EW'(iteration_limit);
		end
		limit_eff = CW'(lim_e);
	end

	// multiplier operand select
	always_comb begin
		a0 = zr_q; b0 = zr_q;
		a1 = zi_q; b1 = zi_q;
		a2 = zr_q; b2 = zi_q;
		unique case (cmd.op_sel)
			OP_SHAPE: begin
				a0 = x_q;  b0 = x_q;
				a1 = ci_q; b1 = ci_q;
				a2 = y_q;  b2 = y_q;
			end
			OP_CARD: begin
				a0 = q_q; b0 = qx_q;
				a1 = '0;  b1 = '0;
				a2 = '0;  b2 = '0;
			end
			OP_ITER: begin
				a0 = zr_q; b0 = zr_q;
				a1 = zi_q; b1 = zi_q;
				a2 = zr_q; b2 = zi_q;
			end
			default: begin
				a0 = '0; b0 = '0;
				a1 = '0; b1 = '0;
				a2 = '0; b2 = '0;
			end
		endcase
	end

	mbe_mul #(.W(ZW)) u_mul0 (
		.clk(clk), .en1(cmd.mul_en1), .en2(cmd.mul_en2), .a(a0), .b(b0), .p(p0)
	);
	mbe_mul #(.W(ZW)) u_mul1 (
		.clk(clk), .en1(cmd.mul_en1), .en2(cmd.mul_en2), .a(a1), .b(b1), .p(p1)
	);
	mbe_mul #(.W(ZW)) u_mul2 (
		.clk(clk), .en1(cmd.mul_en1), .en2(cmd.mul_en2), .a(a2), .b(b2), .p(p2)
	);

	// shape test: q, bulb radius, cardioid compare
	assign q_sum    = PW1'(p0) + PW1'(p1);
	assign q_next   = q_sum[F +: ZW];
	assign bulb_sum = PW1'(p2) + PW1'(p1);
	assign card     = p0 < ci4_q;
	assign status.hit = card || bulb_q;

	// iteration: |z|^2, stop test, next z
	assign mag     = PW1'(p0) + PW1'(p1);
	assign diff    = PW1'(p0) - PW1'(p1);
	assign zr_next = diff[F +: ZW] + cr_q;
	assign zi_next = p2[F - 1 +: ZW] + ci_q;
	assign status.stop = (mag > MAG_FOUR) || (count_q >= limit_q);

	// saturated |z|^2 in the output format
	assign mag_sat = (|mag[PW1-1:F+MAG_W]) ? '1 : mag[F+MAG_W-1:F];

	// control-like registers and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			limit_q     <= CW'(1);
			hit_q       <= 1'b0;
			res_count_q <= '0;
			res_mag_q   <= '0;
			res_limit_q <= 1'b0;
			res_hit_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= '0;
				limit_q <= limit_eff;
				hit_q   <= 1'b0;
			end
			if (cmd.shape_decide) begin
				hit_q <= status.hit;
			end
			if (cmd.step && !status.stop) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.load_out) begin
				if (hit_q) begin
					res_count_q <= '0;
					res_mag_q   <= '0;
					res_limit_q <= 1'b0;
					res_hit_q   <= 1'b1;
				end else begin
					res_count_q <= COUNT_W'(count_q);
					res_mag_q   <= mag_sat;
					res_limit_q <= (count_q == limit_q);
					res_hit_q   <= 1'b0;
				end
			end
		end
	end

	// point and z registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q <= cr_in;
			ci_q <= ci_in;
			x_q  <= cr_in - Z_QUARTER;
			y_q  <= cr_in + Z_ONE;
			zr_q <= '0;
			zi_q <= '0;
		end
		if (cmd.shape_q) begin
			q_q    <= q_next;
			qx_q   <= q_next + x_q;
			ci4_q  <= p1 >>> 2;
			bulb_q <= bulb_sum < BULB_R;
		end
		if (cmd.step && !status.stop) begin
			zr_q <= zr_next;
			zi_q <= zi_next;
		end
	end

	assign iteration_count     = res_count_q;
	assign final_magnitude_sq  = res_mag_q;
	assign limit_reached       = res_limit_q;
	assign in_cardioid_or_bulb = res_hit_q;

	// checks
	`ASSERT_NEVER(a_count_in_limit, count_q > limit_q, "iteration count passed the limit")
	`ASSERT_NEVER(a_limit_range, (limit_q == '0) || (limit_q > CW'(MAX_LIMIT)), "limit out of range")
	`ASSERT_HOLDS(a_hit_result, res_hit_q |-> (res_count_q == '0 && !res_limit_q && res_mag_q == '0), "shape hit with nonzero result")

endmodule

>>> sv/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time block: APB limit register, controller, datapath.
// Depends on mbe_pkg, mbe_ctrl, mbe_dp (and mbe_mul below it).
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------------
//  s_*      | in  | s_tvalid / s_tready     | s_tdata: c_real, c_imag
//  m_*      | out | m_tvalid / m_tready     | m_tdata: count, |z|^2; m_tuser: flags
//  apb      | in  | psel, penable, pready   | iteration_limit at byte address 0
//
// One point at a time. A shape hit goes from the shape test to the result; otherwise
// n iterations follow, n at most the limit. Points with |c| >= 2 skip the shape test.
// Each iteration passes through the two split-multiplier stages and one update state.
// The result sits in an output register, so the next point is taken while it waits.
// Reset (arst_n, asynchronous) clears the controller and sets the limit to 500.
module mandelbrot_escape_time #(
	parameter int FRACTION_BITS = mbe_pkg::FRACTION_BITS_DEF,
	parameter int MAX_LIMIT     = mbe_pkg::MAX_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input beats
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mbe_pkg::IN_TDATA_W-1:0]      s_tdata,  // [31:0] c_real, [63:32] c_imag
	// result beats
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mbe_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [12:0] iteration_count,
	                                                      // [52:13] final_magnitude_sq, pad
	output logic [mbe_pkg::OUT_TUSER_W-1:0]     m_tuser,  // [0] limit_reached,
	                                                      // [1] in_cardioid_or_bulb
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mbe_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [mbe_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [mbe_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);
	import mbe_pkg::*;

	logic [LIMIT_W-1:0]   limit_q;
	logic [CFG_IDX_W-1:0] reg_idx;
	logic                 reg_wr;
	dp_cmd_t              cmd;
	dp_status_t           status;
	logic [COUNT_W-1:0]   res_count;
	logic [MAG_W-1:0]     res_mag;
	logic                 res_limit, res_hit;

	// APB register access
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (reg_wr && reg_idx == CFG_IDX_W'(REG_ITERATION_LIMIT)) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign prdata = (reg_idx == CFG_IDX_W'(REG_ITERATION_LIMIT)) ? APB_DATA_W'(limit_q) : '0;

	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	mbe_dp #(
		.FRACTION_BITS (FRACTION_BITS),
		.MAX_LIMIT     (MAX_LIMIT)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.c_real              (s_tdata[COORD_W-1:0]),
		.c_imag              (s_tdata[2*COORD_W-1:COORD_W]),
		.iteration_limit     (limit_q),
		.iteration_count     (res_count),
		.final_magnitude_sq  (res_mag),
		.limit_reached       (res_limit),
		.in_cardioid_or_bulb (res_hit)
	);

	// result packing
	assign m_tdata = OUT_TDATA_W'({res_mag, res_count});
	assign m_tuser = {res_hit, res_limit};

endmodule
